FILE: rtl/blvl_pkg.sv
// shared constants, register map and types for the battery level estimator
`timescale 1ns / 1ps
package blvl_pkg;

    // default adc resolution
    localparam int ADC_BITS_DEF = 10;

    // field widths
    localparam int MV_W   = 13;
    localparam int LVL_W  = 7;
    localparam int CNT_W  = 8;
    localparam int SPAN_W = 5;
    localparam int NUM_W  = MV_W + SPAN_W;

    // divider: every segment quotient stays below 32
    localparam int QUO_W     = 5;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // millivolts at full adc scale
    localparam logic [MV_W-1:0] MV_SCALE = MV_W'(5400);

    // level constants
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(100);

    // apb register map
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_FULL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AT_75  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AT_50  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AT_25  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AT_10  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOW    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_NEEDED = 3'd6;

    // register reset values
    localparam logic [MV_W-1:0]  RST_FULL   = MV_W'(4200);
    localparam logic [MV_W-1:0]  RST_AT_75  = MV_W'(3950);
    localparam logic [MV_W-1:0]  RST_AT_50  = MV_W'(3850);
    localparam logic [MV_W-1:0]  RST_AT_25  = MV_W'(3800);
    localparam logic [MV_W-1:0]  RST_AT_10  = MV_W'(3750);
    localparam logic [MV_W-1:0]  RST_LOW    = MV_W'(3700);
    localparam logic [CNT_W-1:0] RST_NEEDED = CNT_W'(3);

    // configuration seen by the datapath
    typedef struct packed {
        logic [MV_W-1:0]  full_mv;
        logic [MV_W-1:0]  mv_at_75;
        logic [MV_W-1:0]  mv_at_50;
        logic [MV_W-1:0]  mv_at_25;
        logic [MV_W-1:0]  mv_at_10;
        logic [MV_W-1:0]  low_mv;
        logic [CNT_W-1:0] low_samples_needed;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mult;
        logic segm;
        logic div;
        logic load_out;
    } t_dp_cmd;

endpackage

FILE: rtl/battery_level_estimator.sv
// battery level estimator top level: apb registers, controller and datapath
// an accepted word is scaled to millivolts, a segment is selected, then a 5-step serial divider runs
// a new input word is taken only after the previous result has been loaded into the output register
// a finished word waits in the output register while the next input word is taken
// reset: synchronous active-low; thresholds return to defaults, low counter and flag clear
`timescale 1ns / 1ps
module battery_level_estimator #(
    parameter int ADC_BITS = blvl_pkg::ADC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ADC_BITS-1:0]                i_adc_sample,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [blvl_pkg::MV_W-1:0]          o_bat_mv,
    output logic [blvl_pkg::LVL_W-1:0]         o_level_percent,
    output logic                               o_battery_low,
    output logic                               o_sleep_request,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [blvl_pkg::PADDR_W-1:0]       paddr,
    input  logic [blvl_pkg::APB_DW-1:0]        pwdata,
    output logic [blvl_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import blvl_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    assign pready = 1'b1;

    // configuration registers
    blvl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // sequencing
    blvl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    blvl_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_adc_sample    (i_adc_sample),
        .o_bat_mv        (o_bat_mv),
        .o_level_percent (o_level_percent),
        .o_battery_low   (o_battery_low),
        .o_sleep_request (o_sleep_request)
    );

endmodule

FILE: rtl/blvl_regs.sv
// apb configuration registers for the battery level estimator
`timescale 1ns / 1ps
module blvl_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [blvl_pkg::PADDR_W-1:0]         paddr,
    input  logic [blvl_pkg::APB_DW-1:0]          pwdata,
    output logic [blvl_pkg::APB_DW-1:0]          prdata,
    output blvl_pkg::t_cfg                       o_cfg
);
    import blvl_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[PADDR_W-1:2];

    // register writes, out-of-range index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_mv            <= RST_FULL;
            r_cfg.mv_at_75           <= RST_AT_75;
            r_cfg.mv_at_50           <= RST_AT_50;
            r_cfg.mv_at_25           <= RST_AT_25;
            r_cfg.mv_at_10           <= RST_AT_10;
            r_cfg.low_mv             <= RST_LOW;
            r_cfg.low_samples_needed <= RST_NEEDED;
        end else if (w_wr) begin
            case (w_idx)
                REG_FULL:   r_cfg.full_mv            <= pwdata[MV_W-1:0];
                REG_AT_75:  r_cfg.mv_at_75           <= pwdata[MV_W-1:0];
                REG_AT_50:  r_cfg.mv_at_50           <= pwdata[MV_W-1:0];
                REG_AT_25:  r_cfg.mv_at_25           <= pwdata[MV_W-1:0];
                REG_AT_10:  r_cfg.mv_at_10           <= pwdata[MV_W-1:0];
                REG_LOW:    r_cfg.low_mv             <= pwdata[MV_W-1:0];
                REG_NEEDED: r_cfg.low_samples_needed <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_FULL:   prdata = APB_DW'(r_cfg.full_mv);
            REG_AT_75:  prdata = APB_DW'(r_cfg.mv_at_75);
            REG_AT_50:  prdata = APB_DW'(r_cfg.mv_at_50);
            REG_AT_25:  prdata = APB_DW'(r_cfg.mv_at_25);
            REG_AT_10:  prdata = APB_DW'(r_cfg.mv_at_10);
            REG_LOW:    prdata = APB_DW'(r_cfg.low_mv);
            REG_NEEDED: prdata = APB_DW'(r_cfg.low_samples_needed);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/blvl_dp.sv
// datapath: millivolt scaling, segment select, serial divider, low counter, output word
`timescale 1ns / 1ps
module blvl_dp #(
    parameter int ADC_BITS = blvl_pkg::ADC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  blvl_pkg::t_dp_cmd              i_cmd,
    input  blvl_pkg::t_cfg                 i_cfg,
    input  logic [ADC_BITS-1:0]            i_adc_sample,
    output logic [blvl_pkg::MV_W-1:0]      o_bat_mv,
    output logic [blvl_pkg::LVL_W-1:0]     o_level_percent,
    output logic                           o_battery_low,
    output logic                           o_sleep_request
);
    import blvl_pkg::*;

    localparam int PROD_W = ADC_BITS + MV_W;

    logic [ADC_BITS-1:0] r_sample;
    logic [MV_W-1:0]     r_mv;
    logic [PROD_W-1:0]   w_prod;

    // segment selection
    logic [MV_W-1:0]   w_lo;
    logic [MV_W-1:0]   w_den;
    logic [LVL_W-1:0]  w_base;
    logic [SPAN_W-1:0] w_span;
    logic              w_zero;
    logic [MV_W-1:0]   w_diff;
    logic [NUM_W-1:0]  w_num;

    // divider state
    logic [LVL_W-1:0] r_base;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic             w_ge;

    // low run tracking
    logic [CNT_W-1:0] r_cnt;
    logic             r_flag;
    logic             r_item_low;
    logic             r_item_sleep;
    logic             w_below;
    logic [CNT_W-1:0] n_cnt;
    logic             n_flag;
    logic             n_sleep;

    // result word
    logic [LVL_W-1:0] w_sum;
    logic [LVL_W-1:0] w_level;
    logic [MV_W-1:0]  r_out_mv;
    logic [LVL_W-1:0] r_out_lvl;
    logic             r_out_low;
    logic             r_out_sleep;

    // sample capture and scaling to millivolts
    assign w_prod = PROD_W'(r_sample) * PROD_W'(MV_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_adc_sample;
        end
        if (i_cmd.mult) begin
            r_mv <= w_prod[PROD_W-1 -: MV_W];
        end
    end

    // pick the segment; full and below-low map to a zero numerator
    always_comb begin
        w_lo   = '0;
        w_den  = MV_W'(1);
        w_base = '0;
        w_span = '0;
        w_zero = 1'b1;
        if (r_mv >= i_cfg.full_mv) begin
            w_base = LVL_MAX;
        end else if (r_mv >= i_cfg.mv_at_75) begin
            w_lo   = i_cfg.mv_at_75;
            w_den  = i_cfg.full_mv - i_cfg.mv_at_75;
            w_base = LVL_W'(75);
            w_span = SPAN_W'(25);
            w_zero = 1'b0;
        end else if (r_mv >= i_cfg.mv_at_50) begin
            w_lo   = i_cfg.mv_at_50;
            w_den  = i_cfg.mv_at_75 - i_cfg.mv_at_50;
            w_base = LVL_W'(50);
            w_span = SPAN_W'(25);
            w_zero = 1'b0;
        end else if (r_mv >= i_cfg.mv_at_25) begin
            w_lo   = i_cfg.mv_at_25;
            w_den  = i_cfg.mv_at_50 - i_cfg.mv_at_25;
            w_base = LVL_W'(25);
            w_span = SPAN_W'(25);
            w_zero = 1'b0;
        end else if (r_mv >= i_cfg.mv_at_10) begin
            w_lo   = i_cfg.mv_at_10;
            w_den  = i_cfg.mv_at_25 - i_cfg.mv_at_10;
            w_base = LVL_W'(10);
            w_span = SPAN_W'(15);
            w_zero = 1'b0;
        end else if (r_mv >= i_cfg.low_mv) begin
            w_lo   = i_cfg.low_mv;
            w_den  = i_cfg.mv_at_10 - i_cfg.low_mv;
            w_span = SPAN_W'(10);
            w_zero = 1'b0;
        end
    end

    assign w_diff = w_zero ? '0 : (r_mv - w_lo);
    assign w_num  = NUM_W'(w_diff) * NUM_W'(w_span);

    // restoring divider, one quotient bit per step
    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.segm) begin
            r_base <= w_base;
            r_rem  <= w_num;
            r_dsh  <= NUM_W'(w_den) << (QUO_W - 1);
            r_quo  <= '0;
        end else if (i_cmd.div) begin
            r_rem  <= w_ge ? (r_rem - r_dsh) : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quo  <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    // consecutive low sample counter
    assign w_below = (r_mv < i_cfg.low_mv);

    always_comb begin
        n_cnt   = '0;
        n_flag  = 1'b0;
        n_sleep = 1'b0;
        if (w_below) begin
            n_cnt  = (r_cnt == {CNT_W{1'b1}}) ? r_cnt : (r_cnt + CNT_W'(1));
            n_flag = r_flag;
            if ((n_cnt >= i_cfg.low_samples_needed) && !r_flag) begin
                n_flag  = 1'b1;
                n_sleep = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_flag <= 1'b0;
        end else if (i_cmd.segm) begin
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.segm) begin
            r_item_low   <= n_flag;
            r_item_sleep <= n_sleep;
        end
    end

    // level with clamp
    assign w_sum   = r_base + LVL_W'(r_quo);
    assign w_level = (w_sum > LVL_MAX) ? LVL_MAX : w_sum;

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_mv    <= '0;
            r_out_lvl   <= '0;
            r_out_low   <= 1'b0;
            r_out_sleep <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_mv    <= r_mv;
            r_out_lvl   <= w_level;
            r_out_low   <= r_item_low;
            r_out_sleep <= r_item_sleep;
        end
    end

    assign o_bat_mv        = r_out_mv;
    assign o_level_percent = r_out_lvl;
    assign o_battery_low   = r_out_low;
    assign o_sleep_request = r_out_sleep;

    // the flag never stands without a counted low sample
    a_flag_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |-> (r_cnt != '0))
        else $error("low flag set with zero run count");

    // a sleep request always comes with the low flag
    a_sleep_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_sleep |-> r_out_low)
        else $error("sleep request without low flag");

    // level never exceeds full scale
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_lvl <= LVL_MAX)
        else $error("level above 100 percent");

endmodule

FILE: rtl/blvl_ctrl.sv
// controller: sequences scaling, segment select and divide, owns both handshakes
`timescale 1ns / 1ps
module blvl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output blvl_pkg::t_dp_cmd o_cmd
);
    import blvl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MULT = 5'b00010,
        S_SEGM = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_accept;
    logic              w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        o_cmd.load_in  = w_accept;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_SEGM;
            end
            S_SEGM: begin
                o_cmd.segm = 1'b1;
                n_step     = STEP_W'(DIV_STEPS - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_step    = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // an accepted word starts the scaling step next
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MULT))
        else $error("accepted word did not start processing");

    // a pending word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.load_out)
        else $error("output word overwritten while pending");

    // the last divide step hands over to the finish state
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == '0) |=> (r_state == S_FIN))
        else $error("divider step count broken");

    // a loaded word shows as valid next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded word not flagged valid");

endmodule

FILE: verif/blvl_reading_check.sv
// watches the battery level estimator channels, predicts each reading and compares it
`timescale 1ns / 1ps
module blvl_reading_check #(
    parameter int ADC_BITS = blvl_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [ADC_BITS-1:0]             i_adc_sample,
    // output channel
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [blvl_pkg::MV_W-1:0]       i_bat_mv,
    input  logic [blvl_pkg::LVL_W-1:0]      i_level_percent,
    input  logic                            i_battery_low,
    input  logic                            i_sleep_request,
    // configuration port
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [blvl_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [blvl_pkg::APB_DW-1:0]     i_pwdata,
    // status toward the testbench top
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import blvl_pkg::*;

    localparam int unsigned       MV_FULL_SCALE = 5400;
    localparam logic [CNT_W-1:0]  RUN_MAX       = '1;

    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic [LVL_W-1:0] lvl;
        logic             low;
        logic             sleep;
    } t_reading;

    // readings still owed by the block, oldest first
    t_reading         expected_readings[$];

    // shadow of the threshold registers and the low-run state
    t_cfg             cfg;
    logic [CNT_W-1:0] low_run;
    logic             low_flag;
    int               fails;
    int               checked;

    // one line per mismatch, and count it
    task automatic report_failure(input string msg);
        $display("[%0t] mismatch %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_failure($sformatf("%s: got %0d, want %0d", name, got, want));
        end
    endtask

    // linear interpolation inside one segment, lo <= v < hi
    function automatic int unsigned segment_level(input int unsigned v, input int unsigned lo,
                                                  input int unsigned hi,
                                                  input int unsigned base,
                                                  input int unsigned span);
        return base + (v - lo) * span / (hi - lo);
    endfunction

    // percentage from millivolts, segments tried from the top down
    function automatic logic [LVL_W-1:0] level_for(input int unsigned v);
        int unsigned lvl;
        if (v >= cfg.full_mv) begin
            lvl = 100;
        end else if (v >= cfg.mv_at_75) begin
            lvl = segment_level(v, 32'(cfg.mv_at_75), 32'(cfg.full_mv), 75, 25);
        end else if (v >= cfg.mv_at_50) begin
            lvl = segment_level(v, 32'(cfg.mv_at_50), 32'(cfg.mv_at_75), 50, 25);
        end else if (v >= cfg.mv_at_25) begin
            lvl = segment_level(v, 32'(cfg.mv_at_25), 32'(cfg.mv_at_50), 25, 25);
        end else if (v >= cfg.mv_at_10) begin
            lvl = segment_level(v, 32'(cfg.mv_at_10), 32'(cfg.mv_at_25), 10, 15);
        end else if (v >= cfg.low_mv) begin
            lvl = segment_level(v, 32'(cfg.low_mv), 32'(cfg.mv_at_10), 0, 10);
        end else begin
            lvl = 0;
        end
        if (lvl > 100) begin
            lvl = 100;
        end
        return LVL_W'(lvl);
    endfunction

    // reading for one sample; advances the low-run counter and flag
    function automatic t_reading predict_reading(input logic [ADC_BITS-1:0] sample);
        int unsigned mv;
        t_reading    r;
        mv      = (32'(sample) * MV_FULL_SCALE) >> ADC_BITS;
        r.mv    = MV_W'(mv);
        r.lvl   = level_for(mv);
        r.sleep = 1'b0;
        if (mv < cfg.low_mv) begin
            if (low_run != RUN_MAX) begin
                low_run++;
            end
            if (low_run >= cfg.low_samples_needed && !low_flag) begin
                low_flag = 1'b1;
                r.sleep  = 1'b1;
            end
        end else begin
            low_run  = '0;
            low_flag = 1'b0;
        end
        r.low = low_flag;
        return r;
    endfunction

    // sample both channels and the register port at every edge
    always @(posedge i_clk) begin : watch
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            cfg      = '{RST_FULL, RST_AT_75, RST_AT_50, RST_AT_25, RST_AT_10, RST_LOW,
                         RST_NEEDED};
            low_run  = '0;
            low_flag = 1'b0;
            expected_readings.delete();
        end else begin
            // register write, unmapped indexes dropped
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_FULL:   cfg.full_mv            = i_pwdata[MV_W-1:0];
                    REG_AT_75:  cfg.mv_at_75           = i_pwdata[MV_W-1:0];
                    REG_AT_50:  cfg.mv_at_50           = i_pwdata[MV_W-1:0];
                    REG_AT_25:  cfg.mv_at_25           = i_pwdata[MV_W-1:0];
                    REG_AT_10:  cfg.mv_at_10           = i_pwdata[MV_W-1:0];
                    REG_LOW:    cfg.low_mv             = i_pwdata[MV_W-1:0];
                    REG_NEEDED: cfg.low_samples_needed = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // accepted sample word
            if (i_in_valid && i_in_ready) begin
                expected_readings.push_back(predict_reading(i_adc_sample));
            end
            // accepted result word
            if (i_out_valid && i_out_ready) begin
                got = '{i_bat_mv, i_level_percent, i_battery_low, i_sleep_request};
                if (expected_readings.size() == 0) begin
                    report_failure($sformatf("word with none expected: mv %0d level %0d",
                                             got.mv, got.lvl));
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    compare_field("bat_mv", int'(got.mv), int'(want.mv));
                    compare_field("level_percent", int'(got.lvl), int'(want.lvl));
                    compare_field("battery_low", int'(got.low), int'(want.low));
                    compare_field("sleep_request", int'(got.sleep), int'(want.sleep));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_readings.size();
        o_checked    <= checked;
    end

endmodule

FILE: verif/battery_level_estimator_tb.sv
// testbench top for battery_level_estimator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module battery_level_estimator_tb;
    import blvl_pkg::*;

    localparam int ADC_BITS      = ADC_BITS_DEF;
    localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
    localparam int MV_FULL_SCALE = 5400;
    localparam int MV_MAX        = (1 << MV_W) - 1;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 12;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ADC_BITS-1:0]  i_adc_sample = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [MV_W-1:0]      o_bat_mv;
    logic [LVL_W-1:0]     o_level_percent;
    logic                 o_battery_low;
    logic                 o_sleep_request;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int fail_count;
    int pending_words;
    int checked_words;

    // idling percentages per cycle
    int send_idle_pct = 10;
    int stall_pct = 60;
    int samples_sent = 0;
    int settings_used = 1;
    int cycle_count = 0;

    // thresholds in force, used to aim samples: full, 75, 50, 25, 10, low
    int stim_th [6] = '{int'(RST_FULL), int'(RST_AT_75), int'(RST_AT_50), int'(RST_AT_25),
                        int'(RST_AT_10), int'(RST_LOW)};
    int stim_needed = int'(RST_NEEDED);

    battery_level_estimator #(
        .ADC_BITS(ADC_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_adc_sample    (i_adc_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_bat_mv        (o_bat_mv),
        .o_level_percent (o_level_percent),
        .o_battery_low   (o_battery_low),
        .o_sleep_request (o_sleep_request),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    blvl_reading_check #(
        .ADC_BITS(ADC_BITS)
    ) reading_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_adc_sample    (i_adc_sample),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_bat_mv        (o_bat_mv),
        .i_level_percent (o_level_percent),
        .i_battery_low   (o_battery_low),
        .i_sleep_request (o_sleep_request),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_checked       (checked_words)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycle_count,
                     pending_words);
            $display("status: fail");
            $finish;
        end
    end

    // register write: setup, access, then an idle phase
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // random bits above the register width must be dropped by the block
    function automatic logic [APB_DW-1:0] with_junk(input int value, input int width);
        return ($urandom() << width) | APB_DW'(value);
    endfunction

    // stop sending and wait until every reading has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write all seven registers while the block is idle
    task automatic configure(input int full, input int t75, input int t50, input int t25,
                             input int t10, input int low, input int needed);
        drain();
        stim_th     = '{full & MV_MAX, t75 & MV_MAX, t50 & MV_MAX, t25 & MV_MAX,
                        t10 & MV_MAX, low & MV_MAX};
        stim_needed = needed & 'hFF;
        apb_write(REG_FULL, with_junk(stim_th[0], MV_W));
        apb_write(REG_AT_75, with_junk(stim_th[1], MV_W));
        apb_write(REG_AT_50, with_junk(stim_th[2], MV_W));
        apb_write(REG_AT_25, with_junk(stim_th[3], MV_W));
        apb_write(REG_AT_10, with_junk(stim_th[4], MV_W));
        apb_write(REG_LOW, with_junk(stim_th[5], MV_W));
        apb_write(REG_NEEDED, with_junk(stim_needed, CNT_W));
        settings_used++;
    endtask

    // ascending thresholds with random spacing, equal neighbors allowed
    task automatic random_ladder(input int needed);
        int low;
        int t10;
        int t25;
        int t50;
        int t75;
        low = $urandom_range(0, 4000);
        t10 = low + $urandom_range(0, 250);
        t25 = t10 + $urandom_range(0, 250);
        t50 = t25 + $urandom_range(0, 250);
        t75 = t50 + $urandom_range(0, 250);
        configure(t75 + $urandom_range(0, 250), t75, t50, t25, t10, low, needed);
    endtask

    // smallest sample whose voltage reaches mv
    function automatic int sample_at_mv(input int mv);
        int s;
        s = (mv * (ADC_MAX + 1) + MV_FULL_SCALE - 1) / MV_FULL_SCALE;
        return (s > ADC_MAX) ? ADC_MAX : s;
    endfunction

    // a sample below the low threshold where one exists
    function automatic int below_low();
        int lim;
        lim = sample_at_mv(stim_th[5]);
        return (lim == 0) ? $urandom_range(ADC_MAX) : $urandom_range(lim - 1);
    endfunction

    // mostly near a threshold, some uniform, some low
    function automatic int pick_sample();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 20) begin
            return $urandom_range(ADC_MAX);
        end
        if (r < 80) begin
            s = sample_at_mv(stim_th[$urandom_range(5)]) + $urandom_range(4) - 2;
            return (s < 0) ? 0 : ((s > ADC_MAX) ? ADC_MAX : s);
        end
        return below_low();
    endfunction

    // one sample word, with random idle cycles before it
    task automatic send_sample(input int s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= ADC_BITS'(s);
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        samples_sent++;
    endtask

    // random samples with runs of low ones around the flag count
    task automatic send_random(input int count);
        int run_left;
        run_left = 0;
        repeat (count) begin
            if (run_left == 0 && $urandom_range(9) == 0) begin
                run_left = $urandom_range(1, stim_needed + 3);
            end
            if (run_left > 0) begin
                send_sample(below_low());
                run_left--;
            end else begin
                send_sample(pick_sample());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed at reset thresholds: range ends, alternating bits
        send_sample(0);
        send_sample(ADC_MAX);
        send_sample('h2AA);
        send_sample('h155);
        // each threshold from just above and just below
        foreach (stim_th[k]) begin
            send_sample(sample_at_mv(stim_th[k]));
            send_sample(sample_at_mv(stim_th[k]) - 1);
        end
        // low run up to the flag, one more while flagged, then recovery
        repeat (stim_needed + 1) send_sample(below_low());
        send_sample(ADC_MAX);

        // random at reset thresholds
        send_random(250);

        // every register at the top of its range: all samples low, counter saturates
        configure(MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, 'hFF);
        send_random(270);

        // every register zero, plus a write past the register map
        configure(0, 0, 0, 0, 0, 0, 0);
        apb_write(REG_UNMAPPED, $urandom());
        send_random(40);

        // sender idles more than the receiver stalls
        send_idle_pct = 60;
        stall_pct     = 10;
        // zero flag count: the first low sample raises the flag
        random_ladder(0);
        send_random(100);
        repeat (3) begin
            random_ladder($urandom_range(1, 6));
            send_random(100);
        end
        // thresholds in any order
        repeat (2) begin
            configure($urandom_range(MV_MAX), $urandom_range(MV_MAX), $urandom_range(MV_MAX),
                      $urandom_range(MV_MAX), $urandom_range(MV_MAX), $urandom_range(MV_MAX),
                      $urandom_range(1, 6));
            send_random(75);
        end

        // no idling on either side
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (2) begin
            random_ladder($urandom_range(1, 4));
            send_random(100);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d samples over %0d threshold settings, checked %0d readings",
                 samples_sent, settings_used, checked_words);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/blvl_pkg.sv
rtl/blvl_regs.sv
rtl/blvl_dp.sv
rtl/blvl_ctrl.sv
rtl/battery_level_estimator.sv
verif/blvl_reading_check.sv
verif/battery_level_estimator_tb.sv
